>>> src/clws_pkg.sv
// shared types, constants and codes for the character lcd write sequencer
// no dependencies; used by every module of the block
`default_nettype none

package clws_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_PULSE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_UP_WAIT = 8'd1;
  localparam logic [7:0] ENABLE_PULSE_RESET  = 8'd2;
  localparam logic [7:0] POWER_UP_WAIT_RESET = 8'd40;

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;
  localparam int HOLD_W      = 9;

  // number conversion and queue sizing
  localparam int MAX_DIGITS_DEFAULT = 10;
  localparam int BIN_W              = 32;
  localparam int BCD_DIGITS         = 10;
  localparam int DIGIT_IDX_W        = $clog2(BCD_DIGITS);
  localparam int QUEUE_DEPTH        = 4;

  // lcd command bytes
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
  localparam logic [7:0] ROW1_OFFSET      = 8'h40;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;

  // request kinds
  typedef enum logic [2:0] {
    FUNC_INIT    = 3'd0,
    FUNC_COMMAND = 3'd1,
    FUNC_CHAR    = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_CURSOR  = 3'd4,
    FUNC_NUMBER  = 3'd5
  } func_t;

  // queued bus operations
  typedef enum logic {
    OP_IDLE  = 1'b0,
    OP_WRITE = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic       rs;
    logic [7:0] data;
    logic [1:0] extra;
    logic       last;
  } lcd_op_t;

  // queue handshake between two parts
  typedef struct packed {
    logic    valid;
    lcd_op_t op;
  } op_req_t;

  typedef struct packed {
    logic [7:0] enable_pulse_ms;
    logic [7:0] power_up_wait_ms;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_INIT,
    FS_SINGLE,
    FS_CONVERT,
    FS_SIZE,
    FS_DIGITS
  } front_state_t;

  // register value of zero behaves as one millisecond
  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

`default_nettype wire

>>> src/clws_front.sv
// front part: accepts requests, classifies them, converts numbers to digits
// and pushes bus operations into the queue; depends on clws_pkg
`default_nettype none

module clws_front #(
  parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      func,
  input  wire logic [clws_pkg::BIN_W-1:0]      value,
  input  wire logic                            row,
  input  wire logic [5:0]                      col,
  output clws_pkg::op_req_t                    push,
  input  wire logic                            push_ready
);

  localparam int BCD_W = 4 * clws_pkg::BCD_DIGITS;

  clws_pkg::front_state_t state, state_next;
  logic [2:0]                         step;
  logic [4:0]                         conv_count;
  logic [clws_pkg::BIN_W-1:0]         bin;
  logic [BCD_W-1:0]                   bcd;
  logic [BCD_W-1:0]                   bcd_adj;
  clws_pkg::lcd_op_t                  single_op;
  clws_pkg::lcd_op_t                  init_op;
  logic [clws_pkg::DIGIT_IDX_W-1:0]   digit_idx;
  logic [clws_pkg::DIGIT_IDX_W-1:0]   top_idx;
  logic [3:0]                         cur_digit;
  logic                               accept;

  assign in_ready = (state == clws_pkg::FS_IDLE);
  assign accept   = in_valid && in_ready;

  // add-three correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < clws_pkg::BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // highest nonzero digit, clamped to the digit limit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < clws_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        top_idx = clws_pkg::DIGIT_IDX_W'(i);
      end
    end
    if (top_idx > clws_pkg::DIGIT_IDX_W'(MAX_DIGITS - 1)) begin
      top_idx = clws_pkg::DIGIT_IDX_W'(MAX_DIGITS - 1);
    end
  end

  assign cur_digit = bcd[4*digit_idx +: 4];

  // fixed init sequence
  always_comb begin
    init_op.kind  = clws_pkg::OP_WRITE;
    init_op.rs    = 1'b0;
    init_op.last  = 1'b0;
    init_op.data  = 8'h00;
    init_op.extra = 2'd0;
    case (step)
      3'd0: begin
        init_op.kind = clws_pkg::OP_IDLE;
      end
      3'd1: begin
        init_op.data  = clws_pkg::CMD_FUNCTION_SET;
        init_op.extra = 2'd1;
      end
      3'd2: begin
        init_op.data  = clws_pkg::CMD_DISPLAY_ON;
        init_op.extra = 2'd1;
      end
      3'd3: begin
        init_op.data  = clws_pkg::CMD_CLEAR;
        init_op.extra = 2'd2;
      end
      default: begin
        init_op.data = clws_pkg::CMD_ENTRY_MODE;
        init_op.last = 1'b1;
      end
    endcase
  end

  // next state and queue request
  always_comb begin
    state_next = state;
    push       = '0;
    case (state)
      clws_pkg::FS_IDLE: begin
        if (accept) begin
          case (func)
            clws_pkg::FUNC_INIT:    state_next = clws_pkg::FS_INIT;
            clws_pkg::FUNC_COMMAND: state_next = clws_pkg::FS_SINGLE;
            clws_pkg::FUNC_CHAR:    state_next = clws_pkg::FS_SINGLE;
            clws_pkg::FUNC_CLEAR:   state_next = clws_pkg::FS_SINGLE;
            clws_pkg::FUNC_CURSOR:  state_next = clws_pkg::FS_SINGLE;
            clws_pkg::FUNC_NUMBER: begin
              if (value != '0) begin
                state_next = clws_pkg::FS_CONVERT;
              end
            end
            default: state_next = clws_pkg::FS_IDLE;
          endcase
        end
      end
      clws_pkg::FS_INIT: begin
        push.valid = 1'b1;
        push.op    = init_op;
        if (push_ready && step == 3'd4) begin
          state_next = clws_pkg::FS_IDLE;
        end
      end
      clws_pkg::FS_SINGLE: begin
        push.valid = 1'b1;
        push.op    = single_op;
        if (push_ready) begin
          state_next = clws_pkg::FS_IDLE;
        end
      end
      clws_pkg::FS_CONVERT: begin
        if (conv_count == 5'd31) begin
          state_next = clws_pkg::FS_SIZE;
        end
      end
      clws_pkg::FS_SIZE: begin
        state_next = clws_pkg::FS_DIGITS;
      end
      clws_pkg::FS_DIGITS: begin
        push.valid    = 1'b1;
        push.op.kind  = clws_pkg::OP_WRITE;
        push.op.rs    = 1'b1;
        push.op.data  = clws_pkg::ASCII_ZERO + {4'd0, cur_digit};
        push.op.extra = 2'd0;
        push.op.last  = (digit_idx == '0);
        if (push_ready && digit_idx == '0) begin
          state_next = clws_pkg::FS_IDLE;
        end
      end
      default: state_next = clws_pkg::FS_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clws_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      conv_count <= '0;
      digit_idx  <= '0;
    end else begin
      case (state)
        clws_pkg::FS_IDLE: begin
          step       <= '0;
          conv_count <= '0;
          bin        <= value;
          bcd        <= '0;
        end
        clws_pkg::FS_INIT: begin
          if (push_ready) begin
            step <= step + 3'd1;
          end
        end
        clws_pkg::FS_CONVERT: begin
          {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
          conv_count <= conv_count + 5'd1;
        end
        clws_pkg::FS_SIZE: begin
          digit_idx <= top_idx;
        end
        clws_pkg::FS_DIGITS: begin
          if (push_ready && digit_idx != '0) begin
            digit_idx <= digit_idx - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // single write for command, character, clear and cursor requests
  always_ff @(posedge clk) begin
    if (accept) begin
      single_op.kind  <= clws_pkg::OP_WRITE;
      single_op.extra <= 2'd0;
      single_op.last  <= 1'b1;
      single_op.rs    <= (func == clws_pkg::FUNC_CHAR);
      case (func)
        clws_pkg::FUNC_CLEAR:  single_op.data <= clws_pkg::CMD_CLEAR;
        clws_pkg::FUNC_CURSOR: begin
          single_op.data <= ({2'b00, col} + (row ? clws_pkg::ROW1_OFFSET : 8'h00))
                            | clws_pkg::CMD_SET_ADDR;
        end
        default: single_op.data <= value[7:0];
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/clws_queue.sv
// short queue of bus operations between the front and back parts
// depends on clws_pkg
`default_nettype none

module clws_queue #(
  parameter int DEPTH = clws_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire clws_pkg::op_req_t  push,
  output logic                    push_ready,
  output logic                    pop_valid,
  output clws_pkg::lcd_op_t       pop_op,
  input  wire logic               pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clws_pkg::lcd_op_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/clws_back.sv
// back part: expands each queued operation into timed pin phases
// behind an output register; depends on clws_pkg
`default_nettype none

module clws_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire clws_pkg::cfg_regs_t          cfg,
  input  wire logic                         pop_valid,
  input  wire clws_pkg::lcd_op_t            pop_op,
  output logic                              pop_ready,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_rs,
  output logic                              out_en,
  output logic [7:0]                        out_byte,
  output logic [clws_pkg::HOLD_W-1:0]       out_hold,
  output logic                              out_last
);

  clws_pkg::lcd_op_t           op;
  logic                        op_valid;
  logic                        second;
  logic                        load_out;
  logic                        op_done;
  logic [clws_pkg::HOLD_W-1:0] pulse;
  logic [clws_pkg::HOLD_W-1:0] idle_hold;
  logic                        ph_rs;
  logic                        ph_en;
  logic [7:0]                  ph_byte;
  logic [clws_pkg::HOLD_W-1:0] ph_hold;
  logic                        ph_last;

  assign load_out  = !out_valid || out_ready;
  assign pop_ready = !op_valid;
  assign op_done   = (op.kind == clws_pkg::OP_IDLE) || second;

  // phase contents for the current operation
  always_comb begin
    pulse     = {1'b0, clws_pkg::at_least_one(cfg.enable_pulse_ms)};
    idle_hold = {1'b0, clws_pkg::at_least_one(cfg.power_up_wait_ms)};
    if (op.kind == clws_pkg::OP_IDLE) begin
      ph_rs   = 1'b0;
      ph_en   = 1'b0;
      ph_byte = 8'h00;
      ph_hold = idle_hold;
      ph_last = op.last;
    end else begin
      ph_rs   = op.rs;
      ph_en   = !second;
      ph_byte = op.data;
      ph_hold = second ? pulse + clws_pkg::HOLD_W'(op.extra) : pulse;
      ph_last = second && op.last;
    end
  end

  // current operation and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
      second   <= 1'b0;
    end else if (!op_valid) begin
      if (pop_valid) begin
        op_valid <= 1'b1;
        second   <= 1'b0;
      end
    end else if (load_out) begin
      op_valid <= !op_done;
      second   <= !op_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!op_valid && pop_valid) begin
      op <= pop_op;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && op_valid) begin
      out_rs   <= ph_rs;
      out_en   <= ph_en;
      out_byte <= ph_byte;
      out_hold <= ph_hold;
      out_last <= ph_last;
    end
  end

endmodule

`default_nettype wire

>>> src/char_lcd_write_sequencer_unit.sv
// top level of the character lcd write sequencer: configuration registers,
// front part, operation queue and back part; depends on clws_pkg and submodules
// path: a request passes the front state register, a queue entry, the back operation
//   register and the output register; a number first runs a 32-step binary to bcd loop
// flow: the front takes a new request only once it has pushed every operation of the last
//   one, and it pushes only while the queue has room; the back takes a new operation only
//   after the last phase of the current one has been loaded into the output register
// reset: synchronous; queue emptied, enable pulse 2 ms, power-up wait 40 ms
`default_nettype none

module char_lcd_write_sequencer_unit #(
  parameter int MAX_DIGITS  = clws_pkg::MAX_DIGITS_DEFAULT,
  parameter int QUEUE_DEPTH = clws_pkg::QUEUE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // value [31:0], row [32], col [38:33], zero pad [39]
  input  wire logic [clws_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func [2:0]
  input  wire logic [clws_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  // phase stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // reg_select [0], enable_level [1], bus_byte [9:2], hold_ms [18:10], zero pad [23:19]
  output logic [clws_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  output logic                                      m_axis_tlast,
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [clws_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [7:0]                           cfg_data
);

  clws_pkg::cfg_regs_t         cfg;
  clws_pkg::op_req_t           push;
  logic                        push_ready;
  logic                        pop_valid;
  clws_pkg::lcd_op_t           pop_op;
  logic                        pop_ready;
  logic                        out_rs;
  logic                        out_en;
  logic [7:0]                  out_byte;
  logic [clws_pkg::HOLD_W-1:0] out_hold;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_pulse_ms  <= clws_pkg::ENABLE_PULSE_RESET;
      cfg.power_up_wait_ms <= clws_pkg::POWER_UP_WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clws_pkg::REG_ENABLE_PULSE:  cfg.enable_pulse_ms  <= cfg_data;
        clws_pkg::REG_POWER_UP_WAIT: cfg.power_up_wait_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request classification and digit conversion
  clws_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .func       (s_axis_tuser[2:0]),
    .value      (s_axis_tdata[31:0]),
    .row        (s_axis_tdata[32]),
    .col        (s_axis_tdata[38:33]),
    .push       (push),
    .push_ready (push_ready)
  );

  // operation queue
  clws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  // phase generation
  clws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop_ready (pop_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rs    (out_rs),
    .out_en    (out_en),
    .out_byte  (out_byte),
    .out_hold  (out_hold),
    .out_last  (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = {5'd0, out_hold, out_byte, out_en, out_rs};

endmodule

`default_nettype wire

>>> tb/char_lcd_write_sequencer_unit_test.sv
// self-checking testbench for char_lcd_write_sequencer_unit: directed table, then random requests
// under several register settings, each lcd phase checked against a local phase predictor or
// a typed-in table write; depends on clws_pkg and the char_lcd_write_sequencer_unit rtl
module char_lcd_write_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import clws_pkg::*;

  // request kinds with no phases
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  // register indexes past the last register
  localparam logic [CFG_INDEX_W-1:0] REG_PAST_END = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP      = 8'hFF;
  localparam int DIGIT_LIMIT   = MAX_DIGITS_DEFAULT;
  localparam int HOLD_OFF      = 64;   // covers the number conversion loop
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ROUNDS = 6;
  localparam int ROUND_ITEMS   = 80;
  // table row outcome: predicted, no phases, or one write typed in
  localparam int ROW_PREDICT = -1;
  localparam int ROW_SILENT  = 0;
  localparam int ROW_WRITE   = 2;
  localparam logic [8:0] RESET_HOLD = 9'd2;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [7:0] bus;
    logic [8:0] hold;
    logic       last;
  } lcd_phase_t;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] value;
    logic        row;
    logic [5:0]  col;
    int          outcome;
    logic        rs;
    logic [7:0]  bus;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // predictor copy of the registers
  logic [7:0] pulse_ms = ENABLE_PULSE_RESET;
  logic [7:0] power_up_ms = POWER_UP_WAIT_RESET;

  lcd_phase_t pending_phases[$];
  lcd_phase_t request_phases[$];
  lcd_phase_t want;
  lcd_phase_t got;
  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  steady = 1'b0;

  stim_row_t directed_rows [21] = '{
    '{FUNC_INIT,     32'h0,        1'b0, 6'd0,  ROW_PREDICT, 1'b0, 8'h00},
    '{FUNC_COMMAND,  32'h0,        1'b0, 6'd0,  ROW_WRITE,   1'b0, 8'h00},
    '{FUNC_COMMAND,  32'hFFFFFFFF, 1'b1, 6'd63, ROW_WRITE,   1'b0, 8'hFF},
    '{FUNC_COMMAND,  32'h5A5A5AA5, 1'b0, 6'd21, ROW_WRITE,   1'b0, 8'hA5},
    '{FUNC_CHAR,     32'h00000041, 1'b0, 6'd0,  ROW_WRITE,   1'b1, 8'h41},
    '{FUNC_CHAR,     32'hFFFFFF00, 1'b1, 6'd42, ROW_WRITE,   1'b1, 8'h00},
    '{FUNC_CHAR,     32'h000000FF, 1'b0, 6'd0,  ROW_WRITE,   1'b1, 8'hFF},
    '{FUNC_CLEAR,    32'h12345678, 1'b1, 6'd63, ROW_WRITE,   1'b0, 8'h01},
    '{FUNC_CURSOR,   32'h0,        1'b0, 6'd0,  ROW_WRITE,   1'b0, 8'h80},
    '{FUNC_CURSOR,   32'hFFFFFFFF, 1'b1, 6'd63, ROW_WRITE,   1'b0, 8'hFF},
    '{FUNC_CURSOR,   32'h0,        1'b0, 6'd63, ROW_WRITE,   1'b0, 8'hBF},
    '{FUNC_CURSOR,   32'h0,        1'b1, 6'd0,  ROW_WRITE,   1'b0, 8'hC0},
    '{FUNC_NUMBER,   32'h0,        1'b1, 6'd63, ROW_SILENT,  1'b0, 8'h00},
    '{FUNC_NUMBER,   32'd7,        1'b0, 6'd0,  ROW_PREDICT, 1'b0, 8'h00},
    '{FUNC_NUMBER,   32'hFFFFFFFF, 1'b0, 6'd0,  ROW_PREDICT, 1'b0, 8'h00},
    '{FUNC_NUMBER,   32'd1000000000, 1'b0, 6'd0, ROW_PREDICT, 1'b0, 8'h00},
    '{FUNC_NUMBER,   32'd10,       1'b0, 6'd0,  ROW_PREDICT, 1'b0, 8'h00},
    '{FUNC_SPARE_LO, 32'hFFFFFFFF, 1'b1, 6'd63, ROW_SILENT,  1'b0, 8'h00},
    '{FUNC_SPARE_HI, 32'h0,        1'b0, 6'd0,  ROW_SILENT,  1'b0, 8'h00},
    '{FUNC_INIT,     32'hFFFFFFFF, 1'b1, 6'd63, ROW_PREDICT, 1'b0, 8'h00},
    '{FUNC_NUMBER,   32'h80000000, 1'b1, 6'd5,  ROW_PREDICT, 1'b0, 8'h00}
  };

  char_lcd_write_sequencer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one pin phase of the current request
  function automatic void add_phase(logic rs, logic en, logic [7:0] bus, logic [8:0] hold);
    request_phases.push_back('{rs: rs, en: en, bus: bus, hold: hold, last: 1'b0});
  endfunction

  // enable high, then enable low with the extra wait
  function automatic void add_write(logic rs, logic [7:0] bus, logic [8:0] extra);
    logic [8:0] pulse;
    pulse = (pulse_ms == 8'd0) ? 9'd1 : {1'b0, pulse_ms};
    add_phase(rs, 1'b1, bus, pulse);
    add_phase(rs, 1'b0, bus, pulse + extra);
  endfunction

  // expected phases of one request, appended to the pending store
  function automatic void predict_lcd_phases(logic [2:0] func, logic [31:0] value,
                                             logic row, logic [5:0] col);
    logic [7:0]  digits [DIGIT_LIMIT];
    logic [31:0] rest;
    logic [7:0]  addr;
    lcd_phase_t  tail;
    int          len;
    request_phases.delete();
    case (func)
      FUNC_INIT: begin
        add_phase(1'b0, 1'b0, 8'h00, (power_up_ms == 8'd0) ? 9'd1 : {1'b0, power_up_ms});
        add_write(1'b0, CMD_FUNCTION_SET, 9'd1);
        add_write(1'b0, CMD_DISPLAY_ON, 9'd1);
        add_write(1'b0, CMD_CLEAR, 9'd2);
        add_write(1'b0, CMD_ENTRY_MODE, 9'd0);
      end
      FUNC_COMMAND: add_write(1'b0, value[7:0], 9'd0);
      FUNC_CHAR:    add_write(1'b1, value[7:0], 9'd0);
      FUNC_CLEAR:   add_write(1'b0, CMD_CLEAR, 9'd0);
      FUNC_CURSOR: begin
        addr = ({2'b00, col} + (row ? ROW1_OFFSET : 8'h00)) | CMD_SET_ADDR;
        add_write(1'b0, addr, 9'd0);
      end
      FUNC_NUMBER: begin
        rest = value;
        len = 0;
        while (rest != 0 && len < DIGIT_LIMIT) begin
          digits[len] = 8'(rest % 10);
          rest = rest / 10;
          len++;
        end
        // most significant digit first
        while (len > 0) begin
          len--;
          add_write(1'b1, digits[len] + ASCII_ZERO, 9'd0);
        end
      end
      default: ;
    endcase
    if (request_phases.size() > 0) begin
      tail = request_phases.pop_back();
      tail.last = 1'b1;
      request_phases.push_back(tail);
    end
    foreach (request_phases[i]) pending_phases.push_back(request_phases[i]);
  endfunction

  // drive one request, at times after a random gap, and wait until taken
  task automatic send_request(logic [2:0] func, logic [31:0] value, logic row, logic [5:0] col);
    if (!steady && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {1'b0, col, row, value};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop sending and wait until every expected phase has come, then idle for the hold-off if asked
  task automatic drain_phases(bit hold_off);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_phases.size() != 0);
    if (hold_off) repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_ENABLE_PULSE:  pulse_ms = data;
      REG_POWER_UP_WAIT: power_up_ms = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [2:0]  func;
    logic [31:0] value;
    int          pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table at reset register values
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].func, directed_rows[i].value,
                   directed_rows[i].row, directed_rows[i].col);
      if (directed_rows[i].outcome == ROW_PREDICT)
        predict_lcd_phases(directed_rows[i].func, directed_rows[i].value,
                           directed_rows[i].row, directed_rows[i].col);
      else if (directed_rows[i].outcome == ROW_WRITE) begin
        pending_phases.push_back('{rs: directed_rows[i].rs, en: 1'b1,
                                   bus: directed_rows[i].bus, hold: RESET_HOLD, last: 1'b0});
        pending_phases.push_back('{rs: directed_rows[i].rs, en: 1'b0,
                                   bus: directed_rows[i].bus, hold: RESET_HOLD, last: 1'b1});
      end
    end

    // random rounds, each after its own register writes
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      drain_phases(1'b1);
      case (round)
        0: begin
          write_register(REG_ENABLE_PULSE, 8'd0);
          write_register(REG_POWER_UP_WAIT, 8'd0);
        end
        1: begin
          write_register(REG_ENABLE_PULSE, 8'd255);
          write_register(REG_POWER_UP_WAIT, 8'd255);
        end
        2: begin
          write_register(REG_ENABLE_PULSE, 8'd1);
          write_register(REG_POWER_UP_WAIT, 8'd1);
        end
        3: begin
          // writes past the last register change nothing
          write_register(REG_PAST_END, 8'($urandom));
          write_register(REG_TOP, 8'($urandom));
        end
        default: begin
          write_register(REG_ENABLE_PULSE, 8'($urandom_range(255, 1)));
          write_register(REG_POWER_UP_WAIT, 8'($urandom_range(255)));
        end
      endcase
      // one round with no idling on either side
      steady = (round == 1);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 8) func = FUNC_INIT;
        else if (pick < 25) func = FUNC_COMMAND;
        else if (pick < 45) func = FUNC_CHAR;
        else if (pick < 53) func = FUNC_CLEAR;
        else if (pick < 70) func = FUNC_CURSOR;
        else if (pick < 96) func = FUNC_NUMBER;
        else func = ($urandom_range(1) != 0) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
        value = $urandom;
        // spread the digit count of numbers
        if (func == FUNC_NUMBER) begin
          value = value >> $urandom_range(31);
          if ($urandom_range(19) == 0) value = 32'd0;
        end
        send_request(func, value, 1'($urandom), 6'($urandom));
        predict_lcd_phases(func, value, s_axis_tdata[32], s_axis_tdata[38:33]);
        if ($urandom_range(49) == 0) drain_phases(1'b0);
      end
      steady = 1'b0;
    end

    drain_phases(1'b1);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // phase receiver stalls
  always @(posedge clk)
    m_axis_tready <= steady || ($urandom_range(99) >= 19);

  // phase checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{rs: m_axis_tdata[0], en: m_axis_tdata[1], bus: m_axis_tdata[9:2],
              hold: m_axis_tdata[18:10], last: m_axis_tlast};
      if (pending_phases.size() == 0) begin
        $error("phase with none expected: tdata %06h tlast %0b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_phases.pop_front();
        if (got.rs !== want.rs) begin
          $error("reg_select: expected %0b, got %0b", want.rs, got.rs);
          fail_count++;
        end
        if (got.en !== want.en) begin
          $error("enable_level: expected %0b, got %0b", want.en, got.en);
          fail_count++;
        end
        if (got.bus !== want.bus) begin
          $error("bus_byte: expected %02h, got %02h", want.bus, got.bus);
          fail_count++;
        end
        if (got.hold !== want.hold) begin
          $error("hold_ms: expected %0d, got %0d", want.hold, got.hold);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
